@@ src/kmh_pkg.sv @@
// ---------------------------------------------------------------------------
// kmh_pkg - shared definitions for the k-mer histogram counter
// Port widths, operation codes, nucleotide characters and the decoder that
// turns a character byte into a 2-bit base code.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmh_pkg;

    // Default configuration
    localparam int K_DEF          = 5;
    localparam int COUNT_BITS_DEF = 32;

    // Port field widths
    localparam int FUNC_W   = 2;
    localparam int SYMBOL_W = 8;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 32;
    localparam int ACTIVE_W = 11;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_NT    = 2'd0;  // nucleotide character
    localparam logic [FUNC_W-1:0] FUNC_EOS   = 2'd1;  // end of sequence
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;  // read one counter
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;  // clear histogram

    // Nucleotide characters
    localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
    localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h47;
    localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h54;

    // Base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } nt_code_t;

    // Map a character byte to its base code; ok is low for anything else
    function automatic nt_code_t nt_decode(input logic [SYMBOL_W-1:0] ch);
        nt_code_t res;
        res.ok   = 1'b1;
        res.code = BASE_A;
        unique case (ch)
            CHAR_A:  res.code = BASE_A;
            CHAR_C:  res.code = BASE_C;
            CHAR_G:  res.code = BASE_G;
            CHAR_T:  res.code = BASE_T;
            default: res.ok   = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/kmh_ram.sv @@
// ---------------------------------------------------------------------------
// kmh_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// A read and a write to the same address in one cycle return the old data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/kmer_histogram_counter.sv @@
// ---------------------------------------------------------------------------
// kmer_histogram_counter - k-mer histogram over a nucleotide stream
// Shifts A/C/G/T codes into a K-deep window and counts every complete k-mer
// in a 4^K-entry saturating counter memory; also tracks nonzero entries.
// ---------------------------------------------------------------------------
// Nucleotides, end-of-sequence marks and counter reads are taken one per
// cycle unless a sweep, a pending clear or result back-pressure stalls them;
// each result passes through the stage-1 register into the output register.
// The counters live in one RAM with a single write port: a nucleotide that
// completes a k-mer reads its counter in the transfer cycle and writes the
// incremented value back as its result commits, with the value of the item
// just ahead forwarded when both hit the same entry. A clear returns its
// result, then zeros the RAM one entry per cycle over all 4^K entries (1024
// at K = 5), as also right after reset; no item is taken during a sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmer_histogram_counter #(
    parameter int K          = kmh_pkg::K_DEF,
    parameter int COUNT_BITS = kmh_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Item channel
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [kmh_pkg::FUNC_W-1:0]    func,
    input  wire logic [kmh_pkg::SYMBOL_W-1:0]  symbol,
    input  wire logic [kmh_pkg::INDEX_W-1:0]   entry_index,
    // Result channel
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [kmh_pkg::INDEX_W-1:0]   kmer_index,
    output logic                               counted,
    output logic      [kmh_pkg::COUNT_W-1:0]   count,
    output logic      [kmh_pkg::ACTIVE_W-1:0]  active_kmers
);

    import kmh_pkg::*;

    localparam int IDX_BITS = 2 * K;
    localparam int DEPTH    = 1 << IDX_BITS;
    localparam int RUN_BITS = $clog2(K + 1);
    localparam int NZ_BITS  = IDX_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [RUN_BITS-1:0]   RUN_FULL  = RUN_BITS'(K);
    localparam logic [IDX_BITS-1:0]   LAST_ADDR = IDX_BITS'(DEPTH - 1);

    // -----------------------------------------------------------------------
    // Declarations
    // -----------------------------------------------------------------------
    logic                  accept;
    logic                  commit;
    logic                  s1_adv;
    nt_code_t              nt;

    logic [IDX_BITS-1:0]   window_reg, window_next;
    logic [RUN_BITS-1:0]   run_reg, run_next;
    logic                  a_cnt;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  rd_en;

    logic                  s1_valid_reg, s1_valid_next;
    logic [FUNC_W-1:0]     s1_op_reg;
    logic                  s1_cnt_reg;
    logic [IDX_BITS-1:0]   s1_addr_reg;
    logic                  s1_fwd_reg;
    logic [COUNT_BITS-1:0] s1_fwd_data_reg;

    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                  b_wr;

    logic [NZ_BITS-1:0]    nz_reg, nz_next;

    logic                  sweep_reg, sweep_next;
    logic [IDX_BITS-1:0]   sweep_addr_reg, sweep_addr_next;

    logic                  ram_wr_en;
    logic [IDX_BITS-1:0]   ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;

    logic                  result_valid_reg, result_valid_next;
    logic [INDEX_W-1:0]    kmer_index_reg, kmer_index_next;
    logic                  counted_reg, counted_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [ACTIVE_W-1:0]   active_reg, active_next;

    // -----------------------------------------------------------------------
    // Handshake and pipeline advance
    // -----------------------------------------------------------------------
    assign s1_adv     = !result_valid_reg || !result_stall;
    assign commit     = s1_valid_reg && s1_adv;
    assign item_stall = sweep_reg
                        || (s1_valid_reg && ((s1_op_reg == FUNC_CLEAR) || !s1_adv));
    assign accept     = item_valid && !item_stall;

    // -----------------------------------------------------------------------
    // Stage A: window update and counter read address
    // -----------------------------------------------------------------------
    assign nt = nt_decode(symbol);

    always_comb
    begin
        window_next = window_reg;
        run_next    = run_reg;
        a_cnt       = 1'b0;
        rd_addr     = IDX_BITS'(entry_index);
        unique case (func)
            FUNC_NT:
            begin
                if (nt.ok)
                begin
                    window_next = IDX_BITS'({window_reg, nt.code});
                    run_next    = (run_reg == RUN_FULL) ? run_reg : run_reg + 1'b1;
                    a_cnt       = (run_next == RUN_FULL);
                    rd_addr     = window_next;
                end
                else
                begin
                    run_next = '0;
                end
            end
            FUNC_EOS:
            begin
                window_next = '0;
                run_next    = '0;
            end
            FUNC_READ:
            begin
                a_cnt = 1'b0;
            end
            FUNC_CLEAR:
            begin
                a_cnt = 1'b0;
            end
        endcase
    end

    assign rd_en = accept && ((func == FUNC_NT && a_cnt) || (func == FUNC_READ));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (commit)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Stage B: modify, write back, form the result
    // -----------------------------------------------------------------------
    assign cur     = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign cnt_new = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    assign b_wr    = commit && (s1_op_reg == FUNC_NT) && s1_cnt_reg;

    // Nonzero entry count
    always_comb
    begin
        nz_next = nz_reg;
        if (b_wr && (cur == '0))
        begin
            nz_next = nz_reg + 1'b1;
        end
        else if (commit && (s1_op_reg == FUNC_CLEAR))
        begin
            nz_next = '0;
        end
    end

    // Output register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        kmer_index_next   = kmer_index_reg;
        counted_next      = counted_reg;
        count_next        = count_reg;
        active_next       = active_reg;
        if (commit)
        begin
            result_valid_next = 1'b1;
            kmer_index_next   = '0;
            counted_next      = 1'b0;
            count_next        = '0;
            active_next       = ACTIVE_W'(nz_next);
            unique case (s1_op_reg)
                FUNC_NT:
                begin
                    if (s1_cnt_reg)
                    begin
                        kmer_index_next = INDEX_W'(s1_addr_reg);
                        counted_next    = 1'b1;
                        count_next      = COUNT_W'(cnt_new);
                    end
                end
                FUNC_READ:
                begin
                    kmer_index_next = INDEX_W'(s1_addr_reg);
                    count_next      = COUNT_W'(cur);
                end
                FUNC_EOS:
                begin
                    counted_next = 1'b0;
                end
                FUNC_CLEAR:
                begin
                    counted_next = 1'b0;
                end
            endcase
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Clearing sweep
    // -----------------------------------------------------------------------
    always_comb
    begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        if (sweep_reg)
        begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == LAST_ADDR)
            begin
                sweep_next = 1'b0;
            end
        end
        else if (commit && (s1_op_reg == FUNC_CLEAR))
        begin
            sweep_next = 1'b1;
        end
    end

    // RAM write port: sweep or counter write-back
    assign ram_wr_en   = sweep_reg || b_wr;
    assign ram_wr_addr = sweep_reg ? sweep_addr_reg : s1_addr_reg;
    assign ram_wr_data = sweep_reg ? '0 : cnt_new;

    kmh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // Control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= '0;
            run_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            nz_reg           <= '0;
            sweep_reg        <= 1'b1;
            sweep_addr_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                window_reg <= window_next;
                run_reg    <= run_next;
            end
            s1_valid_reg     <= s1_valid_next;
            nz_reg           <= nz_next;
            sweep_reg        <= sweep_next;
            sweep_addr_reg   <= sweep_addr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // -----------------------------------------------------------------------
    // Payload registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= func;
            s1_cnt_reg      <= a_cnt;
            s1_addr_reg     <= rd_addr;
            // item ahead writes the same entry at this edge: RAM read is stale
            s1_fwd_reg      <= b_wr && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= cnt_new;
        end
        kmer_index_reg <= kmer_index_next;
        counted_reg    <= counted_next;
        count_reg      <= count_next;
        active_reg     <= active_next;
    end

    assign result_valid = result_valid_reg;
    assign kmer_index   = kmer_index_reg;
    assign counted      = counted_reg;
    assign count        = count_reg;
    assign active_kmers = active_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !accept)
        else $error("item transfer during clearing sweep");

    a_sweep_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !s1_valid_reg)
        else $error("write-back pending during clearing sweep");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (s1_op_reg == FUNC_CLEAR)) |=> (sweep_reg && (nz_reg == '0)))
        else $error("clear did not start sweep");

    a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nz_reg <= NZ_BITS'(DEPTH))
        else $error("nonzero entry count exceeds table size");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && counted_reg) |-> (count_reg != '0 && active_reg != '0))
        else $error("counted k-mer with zero count");

endmodule

`default_nettype wire

@@ tb/sv/kmer_histogram_counter_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmer_histogram_counter_tb - self-checking bench for the k-mer histogram
// A scoreboard class keeps its own window, run length, counter table and
// nonzero tally, and predicts one result per transfer. The bench drives
// directed corner items, then random nucleotide runs mixed with reads,
// end-of-sequence marks, noise bytes and clears, under three idle profiles.
// ---------------------------------------------------------------------------

module kmer_histogram_counter_tb;
    import kmh_pkg::*;

    localparam int          KLEN        = K_DEF;
    localparam int          TABLE_SIZE  = 1 << (2 * KLEN);
    localparam logic [INDEX_W-1:0] INDEX_MASK = INDEX_W'(TABLE_SIZE - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam int          HALF_PERIOD = 2;
    localparam int          STUCK_LIMIT = 10000;
    localparam int          DRAIN_WAIT  = 16;

    typedef struct packed {
        logic [INDEX_W-1:0]  idx;
        logic                hit;
        logic [COUNT_W-1:0]  count;
        logic [ACTIVE_W-1:0] active;
    } kmer_result_t;

    // Shadow copy of the counter plus the queue of results it owes
    class kmer_scoreboard;
        logic [COUNT_W-1:0]  hist [TABLE_SIZE];
        logic [INDEX_W-1:0]  window;
        int unsigned         run_len;
        logic [ACTIVE_W-1:0] nonzero;
        kmer_result_t        owed_q [$];
        int unsigned         mismatches;
        int unsigned         results_seen;
        int unsigned         hits;
        int unsigned         reads;
        int unsigned         clears;
        logic [INDEX_W-1:0]  last_hit;

        function new();
            foreach (hist[i])
                hist[i] = '0;
            window       = '0;
            run_len      = 0;
            nonzero      = '0;
            mismatches   = 0;
            results_seen = 0;
            hits         = 0;
            reads        = 0;
            clears       = 0;
            last_hit     = '0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // Advance the shadow state by one accepted item
        function void note_item(logic [FUNC_W-1:0] f, logic [SYMBOL_W-1:0] s,
                                logic [INDEX_W-1:0] e);
            kmer_result_t r;
            logic         ok;
            logic [1:0]   code;
            r    = '0;
            ok   = 1'b1;
            code = BASE_A;
            case (f)
                FUNC_NT:
                begin
                    case (s)
                        CHAR_A:  code = BASE_A;
                        CHAR_C:  code = BASE_C;
                        CHAR_G:  code = BASE_G;
                        CHAR_T:  code = BASE_T;
                        default: ok = 1'b0;
                    endcase
                    if (!ok)
                        run_len = 0;
                    else
                    begin
                        window = ((window << 2) | INDEX_W'(code)) & INDEX_MASK;
                        if (run_len < KLEN)
                            run_len++;
                        if (run_len >= KLEN)
                        begin
                            if (hist[window] == '0)
                                nonzero++;
                            if (hist[window] != COUNT_MAX)
                                hist[window]++;
                            r.idx    = window;
                            r.hit    = 1'b1;
                            r.count  = hist[window];
                            last_hit = window;
                            hits++;
                        end
                    end
                end
                FUNC_EOS:
                begin
                    window  = '0;
                    run_len = 0;
                end
                FUNC_READ:
                begin
                    r.idx   = e & INDEX_MASK;
                    r.count = hist[r.idx];
                    reads++;
                end
                FUNC_CLEAR:
                begin
                    foreach (hist[i])
                        hist[i] = '0;
                    nonzero = '0;
                    clears++;
                end
            endcase
            r.active = nonzero;
            owed_q = {owed_q, r};
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_result(kmer_result_t got);
            kmer_result_t exp;
            results_seen++;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result idx=%0d counted=%0b count=%0d active=%0d",
                             $realtime, got.idx, got.hit, got.count, got.active);
                return;
            end
            exp = owed_q.pop_front();
            if (got.idx !== exp.idx || got.hit !== exp.hit ||
                got.count !== exp.count || got.active !== exp.active)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] mismatch exp idx=%0d counted=%0b count=%0d active=%0d",
                             $realtime, exp.idx, exp.hit, exp.count, exp.active);
                    $display("[%0t]          got idx=%0d counted=%0b count=%0d active=%0d",
                             $realtime, got.idx, got.hit, got.count, got.active);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic [FUNC_W-1:0]    func = FUNC_NT;
    logic [SYMBOL_W-1:0]  symbol = '0;
    logic [INDEX_W-1:0]   entry_index = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [INDEX_W-1:0]   kmer_index;
    logic                 counted;
    logic [COUNT_W-1:0]   count;
    logic [ACTIVE_W-1:0]  active_kmers;

    kmer_scoreboard sb = new();
    int unsigned    send_idle = 0;
    int unsigned    recv_idle = 0;
    int unsigned    items_sent = 0;
    int unsigned    stuck_cycles = 0;

    kmer_histogram_counter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .symbol       (symbol),
        .entry_index  (entry_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kmer_index   (kmer_index),
        .counted      (counted),
        .count        (count),
        .active_kmers (active_kmers)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result({kmer_index, counted, count, active_kmers});
            result_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles", $realtime, STUCK_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [SYMBOL_W-1:0] base_char(input int unsigned code);
        case (code)
            0:       return CHAR_A;
            1:       return CHAR_C;
            2:       return CHAR_G;
            default: return CHAR_T;
        endcase
    endfunction

    // Offer one item, with random idle cycles ahead of it
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SYMBOL_W-1:0] s,
                             input logic [INDEX_W-1:0] e);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        func        <= f;
        symbol      <= s;
        entry_index <= e;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(f, s, e);
        items_sent++;
    endtask

    task automatic send_base(input int unsigned code);
        send_item(FUNC_NT, base_char(code), INDEX_W'($urandom_range(1023)));
    endtask

    // Hold the sender off until every owed result is back
    task automatic drain_results();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic directed_items();
        // short run, then the first full k-mer
        send_base(0);
        send_base(1);
        send_base(2);
        send_base(3);
        send_base(3);
        // invalid characters break the window
        send_item(FUNC_NT, "N", '0);
        send_item(FUNC_NT, 8'h00, '1);
        send_item(FUNC_NT, 8'hFF, '0);
        // lowest index twice, then highest
        repeat (6) send_base(0);
        repeat (5) send_base(3);
        send_item(FUNC_READ, 8'hFF, '1);
        send_item(FUNC_READ, 8'h00, '0);
        send_item(FUNC_EOS, 8'hFF, '1);
        send_item(FUNC_CLEAR, 8'hFF, '1);
        send_item(FUNC_READ, 8'h00, '0);
        send_item(FUNC_NT, "a", '0);
        // a count of the top counter at its maximum is out of reach at 32 bits
    endtask

    task automatic random_items(input int unsigned target);
        int unsigned pick;
        int unsigned len;
        bit          narrow;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // nucleotide run; a narrow alphabet makes counters repeat
                len    = $urandom_range(40, 1);
                narrow = ($urandom_range(2) == 0);
                repeat (len)
                begin
                    if ($urandom_range(99) < 3)
                        send_item(FUNC_NT, SYMBOL_W'($urandom_range(255)),
                                  INDEX_W'($urandom_range(1023)));
                    else if (narrow)
                        send_base($urandom_range(1));
                    else
                        send_base($urandom_range(3));
                end
                if ($urandom_range(1) == 0)
                    send_item(FUNC_EOS, SYMBOL_W'($urandom_range(255)),
                              INDEX_W'($urandom_range(1023)));
            end
            else if (pick < 85)
            begin
                if ($urandom_range(1) == 0)
                    send_item(FUNC_READ, SYMBOL_W'($urandom_range(255)), sb.last_hit);
                else
                    send_item(FUNC_READ, SYMBOL_W'($urandom_range(255)),
                              INDEX_W'($urandom_range(1023)));
            end
            else if (pick < 93)
                send_item(FUNC_NT, SYMBOL_W'($urandom_range(255)),
                          INDEX_W'($urandom_range(1023)));
            else if (pick < 98)
                send_item(FUNC_EOS, SYMBOL_W'($urandom_range(255)),
                          INDEX_W'($urandom_range(1023)));
            else
                send_item(FUNC_CLEAR, SYMBOL_W'($urandom_range(255)),
                          INDEX_W'($urandom_range(1023)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles less than the receiver
        send_idle = 26;
        recv_idle = 68;
        directed_items();
        random_items(340);
        drain_results();

        // roles swapped
        send_idle = 68;
        recv_idle = 26;
        random_items(670);
        drain_results();

        // back to back
        send_idle = 0;
        recv_idle = 0;
        random_items(1000);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("items %0d, results %0d, k-mers counted %0d, reads %0d, clears %0d",
                 items_sent, sb.results_seen, sb.hits, sb.reads, sb.clears);
        $display("mismatches %0d, results still owed %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
src/kmh_pkg.sv
src/kmh_ram.sv
src/kmer_histogram_counter.sv
tb/sv/kmer_histogram_counter_tb.sv
